// ===== hdl/ffba_pkg.sv =====
`timescale 1ns / 1ps

package ffba_pkg;

    // Sizing of the arena and of the free list.
    localparam int ARENA_BYTES    = 16384;
    localparam int HEADER_BYTES   = 32;
    localparam int MIN_DATA_BYTES = 8;
    localparam int FREE_DEPTH     = 16;

    // Field widths of the request and result streams.
    localparam int ADDR_W = 14;
    localparam int SIZE_W = 15;

    // The block size store holds one entry per 8-byte granule of the arena.
    localparam int STORE_DEPTH = ARENA_BYTES / 8;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    // Function codes carried in tuser.
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [IDX_W-1:0]  t_idx;

    // One free-list entry as it moves between neighbouring cells.
    typedef struct packed {
        logic  valid;
        t_addr addr;
        t_size size;
    } t_entry;

    // The search probe that walks down the chain, one cell per cycle.
    typedef struct packed {
        logic  valid;
        logic  hit;
        t_addr addr;
    } t_probe;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic  push;
        logic  remove;
        t_size req;
    } t_cmd;

endpackage

// ===== hdl/first_fit_bump_allocator.sv =====
`timescale 1ns / 1ps

// First-fit arena allocator with a LIFO free list held in a chain of cells.
// Requests arrive on the s_axis channel: tuser holds the function (allocate
// or free), tdata the requested size and the address to be freed. Each
// request gives exactly one result on the m_axis channel: the granted data
// address, a status (ok, out of memory, free list full) and, in tuser, a
// flag set when the block came from the free list.
// The arena size register is written through the cfg channel, which is
// always ready; it should only be written while no request is in flight.
// A free passes the push state, or goes straight to the result state if
// the free list is full. An allocate with an initialised arena starts the
// search probe, which walks the cell chain one cell per cycle; then the
// controller picks reuse or the bump pointer. A zero arena size sends an
// allocate straight to the result state. One request is worked on at a
// time; the next is accepted in the cycle after the result is loaded into
// the output register, even while it still waits for m_axis_tready.
// Reset empties the free list, clears the bump pointer and the arena size;
// the block size store is not cleared. A stalled receiver holds the result
// in the output register and the next request waits there for a free slot.

module first_fit_bump_allocator
    import ffba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: arena_size.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data,
    // tdata: request_size [14:0], free_address [28:15], zero padding above.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // tuser: func [0].
    input  logic [0:0]  s_axis_tuser,
    // tdata: data_address [13:0], status [15:14].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // tuser: reused [0].
    output logic [0:0]  m_axis_tuser
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FREE   = 3'd2;
    localparam logic [2:0] S_RESULT = 3'd3;

    localparam int TOT_W = SIZE_W + 2;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    t_size            r_arena;
    t_size            r_bump;
    t_size            n_bump;
    t_size            r_req;
    t_addr            r_faddr;
    logic [TOT_W-1:0] r_total;
    t_size            r_dsize;
    logic             r_start;
    logic             n_start;
    t_addr            r_res_addr;
    t_addr            n_res_addr;
    logic [1:0]       r_res_status;
    logic [1:0]       n_res_status;
    logic             r_res_reused;
    logic             n_res_reused;
    logic             r_out_valid;
    t_addr            r_out_addr;
    logic [1:0]       r_out_status;
    logic             r_out_reused;
    t_size            r_store_rd;
    t_size            r_store [STORE_DEPTH];

    logic             w_accept;
    logic             w_func;
    t_size            w_in_req;
    t_addr            w_in_faddr;
    t_size            w_floor;
    logic [SIZE_W:0]  w_round;
    logic [SIZE_W:0]  w_data;
    logic [TOT_W-1:0] w_bump_end;
    logic             w_bump_fail;
    t_addr            w_grant;
    logic             w_store_we;
    logic             w_full;
    logic             w_load_out;
    t_cmd             w_cmd;
    t_entry           w_new;
    t_entry           w_tail_next;
    t_probe           w_probe_head;
    t_entry           w_ent   [FREE_DEPTH];
    t_probe           w_probe [FREE_DEPTH];
    logic [FREE_DEPTH-1:0] w_vld;

    // Request fields.
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_func     = s_axis_tuser[0];
    assign w_in_req   = s_axis_tdata[SIZE_W-1:0];
    assign w_in_faddr = s_axis_tdata[SIZE_W +: ADDR_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // Data size: raise to the minimum, then round up to 8 bytes.
    assign w_floor = (w_in_req < SIZE_W'(MIN_DATA_BYTES)) ? SIZE_W'(MIN_DATA_BYTES) : w_in_req;
    assign w_round = {1'b0, w_floor} + (SIZE_W + 1)'(7);
    assign w_data  = {w_round[SIZE_W:3], 3'b000};

    // Bump pointer check against the arena size.
    assign w_bump_end  = TOT_W'(r_bump) + r_total;
    assign w_bump_fail = w_bump_end > TOT_W'(r_arena);
    assign w_grant     = ADDR_W'(r_bump + SIZE_W'(HEADER_BYTES));

    // The free list is full once the oldest cell holds an entry.
    assign w_full = w_vld[FREE_DEPTH-1];

    // Chain of free-list cells, newest entry in cell 0.
    assign w_new        = '{valid: 1'b1, addr: r_faddr, size: r_store_rd};
    assign w_tail_next  = '{valid: 1'b0, addr: '0, size: '0};
    assign w_probe_head = '{valid: r_start, hit: 1'b0, addr: '0};

    for (genvar g = 0; g < FREE_DEPTH; g++) begin : g_cell
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_prev  ((g == 0) ? w_new : w_ent[(g == 0) ? 0 : g - 1]),
            .i_next  ((g == FREE_DEPTH - 1) ? w_tail_next
                                            : w_ent[(g == FREE_DEPTH - 1) ? g : g + 1]),
            .i_probe ((g == 0) ? w_probe_head : w_probe[(g == 0) ? 0 : g - 1]),
            .o_entry (w_ent[g]),
            .o_probe (w_probe[g])
        );
        assign w_vld[g] = w_ent[g].valid;
    end

    // Controller: next state, chain commands and the pending result.
    always_comb begin
        n_state      = r_state;
        n_start      = 1'b0;
        n_bump       = r_bump;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_reused = r_res_reused;
        w_cmd        = '{push: 1'b0, remove: 1'b0, req: r_req};
        w_store_we   = 1'b0;
        w_load_out   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_addr   = '0;
                    n_res_reused = 1'b0;
                    n_res_status = ST_OK;
                    if (w_func == FN_FREE) begin
                        if (w_full) begin
                            n_res_status = ST_FULL;
                            n_state      = S_RESULT;
                        end else begin
                            n_state = S_FREE;
                        end
                    end else if (r_arena == '0) begin
                        n_res_status = ST_OOM;
                        n_state      = S_RESULT;
                    end else begin
                        n_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_FREE: begin
                w_cmd.push = 1'b1;
                n_state    = S_RESULT;
            end
            S_SCAN: begin
                if (w_probe[FREE_DEPTH-1].valid) begin
                    n_state = S_RESULT;
                    if (w_probe[FREE_DEPTH-1].hit) begin
                        w_cmd.remove = 1'b1;
                        n_res_addr   = w_probe[FREE_DEPTH-1].addr;
                        n_res_reused = 1'b1;
                    end else if (w_bump_fail) begin
                        n_res_status = ST_OOM;
                    end else begin
                        w_store_we = 1'b1;
                        n_bump     = SIZE_W'(w_bump_end);
                        n_res_addr = w_grant;
                    end
                end
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_bump      <= '0;
            r_arena     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_bump  <= n_bump;
            if (i_cfg_valid && o_cfg_ready) begin
                r_arena <= (i_cfg_data > SIZE_W'(ARENA_BYTES)) ? SIZE_W'(ARENA_BYTES)
                                                               : i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= w_in_req;
            r_faddr <= w_in_faddr;
            r_total <= TOT_W'(HEADER_BYTES) + TOT_W'(w_data);
            r_dsize <= w_data[SIZE_W-1:0];
        end
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_reused <= n_res_reused;
        if (w_load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_reused <= r_res_reused;
        end
    end

    // Block size store: written when a block is carved, read on a free.
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[IDX_W'(w_grant >> 3)] <= r_dsize;
        end
        if (w_accept && (w_func == FN_FREE)) begin
            r_store_rd <= r_store[IDX_W'(w_in_faddr >> 3)];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_status, r_out_addr};
    assign m_axis_tuser  = r_out_reused;

    // The occupied cells always form one run starting at cell 0.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld >> 1) & ~w_vld) == '0)
        else $error("free list has a hole");

    // The probe only leaves the chain while a search is running.
    a_probe_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[FREE_DEPTH-1].valid |-> (r_state == S_SCAN))
        else $error("probe outside a search");

    // An entry is only unlinked after the probe reported a fit.
    a_remove_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.remove |-> (w_probe[FREE_DEPTH-1].valid && w_probe[FREE_DEPTH-1].hit))
        else $error("removal without a fit");

    // A push always leaves a valid entry at the head of the list.
    a_push_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> w_vld[0])
        else $error("push lost");

endmodule

// ===== hdl/ffba_cell.sv =====
`timescale 1ns / 1ps

module ffba_cell
    import ffba_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_entry i_prev,
    input  t_entry i_next,
    input  t_probe i_probe,
    output t_entry o_entry,
    output t_probe o_probe
);

    logic   r_valid;
    t_addr  r_addr;
    t_size  r_size;
    logic   r_gone;
    logic   r_pv;
    logic   r_phit;
    t_addr  r_paddr;
    logic   w_mine;
    logic   w_hit;

    // This cell fits the request when it holds an entry large enough.
    assign w_mine = r_valid && (r_size >= i_cmd.req);
    assign w_hit  = i_probe.hit || w_mine;

    // Control state: entry valid, probe valid and hit, and removal mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
            r_phit  <= 1'b0;
            r_gone  <= 1'b0;
        end else begin
            r_pv <= i_probe.valid;
            if (i_probe.valid) begin
                r_phit <= w_hit;
                r_gone <= w_hit;
            end
            if (i_cmd.push) begin
                r_valid <= i_prev.valid;
            end else if (i_cmd.remove && r_gone) begin
                r_valid <= i_next.valid;
            end
        end
    end

    // Payload: a push takes the newer neighbour, a removal the older one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_addr <= i_prev.addr;
            r_size <= i_prev.size;
        end else if (i_cmd.remove && r_gone) begin
            r_addr <= i_next.addr;
            r_size <= i_next.size;
        end
        if (i_probe.valid) begin
            r_paddr <= i_probe.hit ? i_probe.addr : r_addr;
        end
    end

    assign o_entry = '{valid: r_valid, addr: r_addr, size: r_size};
    assign o_probe = '{valid: r_pv, hit: r_phit, addr: r_paddr};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ffba_pkg::*;

    // One result as it leaves the allocator.
    typedef struct packed {
        t_addr      addr;
        logic [1:0] status;
        logic       reused;
    } t_grant;

    // One row of the directed table; the expected grant is used only when typed is set.
    typedef struct packed {
        logic       set_arena;
        t_size      arena;
        logic       fn;
        t_size      req;
        t_addr      fa;
        logic       typed;
        t_addr      ex_addr;
        logic [1:0] ex_status;
        logic       ex_reused;
    } t_step_row;

    // The slowest request is an allocate that walks the whole chain; a receiver idle
    // 73 percent of the time makes a long stall very unlikely.
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 325;
    localparam int DIRECTED_LEN = 26;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Predicted allocator state.
    int    arena_limit;
    int    bump_ptr;
    int    free_len;
    t_addr free_addr_q [FREE_DEPTH];
    t_size free_size_q [FREE_DEPTH];
    t_size block_size_mem [STORE_DEPTH];

    // Grants still owed by the allocator, oldest first.
    t_grant pending_grants [$];
    // Addresses handed out, and addresses whose block size has been recorded.
    t_addr  held_blocks [$];
    t_addr  carved_blocks [$];

    int tx_idle_pct = 10;
    int rx_idle_pct = 73;
    int n_errors    = 0;
    int quiet_cycles = 0;
    t_grant want;

    // Directed requests: set_arena, arena, fn, req, fa, typed, ex_addr, ex_status, ex_reused.
    t_step_row directed_rows [DIRECTED_LEN] = '{
        // Allocate before the arena is initialised.
        '{1'b0, 15'd0,     FN_ALLOC, 15'd0,     14'd0,   1'b1, 14'd0,   ST_OOM,  1'b0},
        // Small arena: minimum size, rounding up, then exhaustion.
        '{1'b1, 15'd200,   FN_ALLOC, 15'd0,     14'd0,   1'b1, 14'd32,  ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_ALLOC, 15'd1,     14'd0,   1'b1, 14'd72,  ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_ALLOC, 15'd9,     14'd0,   1'b1, 14'd112, ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_ALLOC, 15'd100,   14'd0,   1'b1, 14'd0,   ST_OOM,  1'b0},
        // Fill the free list, with double frees, then one push too many.
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd112, 1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd32767, 14'd32,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd32,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd32,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd32,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd32,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd32,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd32,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd39,  1'b1, 14'd0,   ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_FREE,  15'd0,     14'd72,  1'b1, 14'd0,   ST_FULL, 1'b0},
        // Only the oldest entry fits, so the whole list is walked and closes up.
        '{1'b0, 15'd0,     FN_ALLOC, 15'd9,     14'd0,   1'b0, 14'd0,   ST_OK,   1'b0},
        // Zero arena refuses even with blocks waiting on the list.
        '{1'b1, 15'd0,     FN_ALLOC, 15'd0,     14'd0,   1'b1, 14'd0,   ST_OOM,  1'b0},
        // Oversized register value acts as the full arena.
        '{1'b1, 15'd32767, FN_ALLOC, 15'd0,     14'd16383, 1'b0, 14'd0, ST_OK,   1'b0},
        '{1'b0, 15'd0,     FN_ALLOC, 15'd16384, 14'd0,   1'b1, 14'd0,   ST_OOM,  1'b0}
    };

    first_fit_bump_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Work out the grant for one request and advance the predicted state.
    function automatic t_grant predict_grant(logic fn, t_size req, t_addr fa);
        t_grant g;
        int     k;
        int     j;
        int     data_bytes;
        g = '{addr: '0, status: ST_OK, reused: 1'b0};
        if (fn == FN_FREE) begin
            if (free_len >= FREE_DEPTH) begin
                g.status = ST_FULL;
            end else begin
                free_addr_q[free_len] = fa;
                free_size_q[free_len] = block_size_mem[fa >> 3];
                free_len++;
            end
            return g;
        end
        if (arena_limit == 0) begin
            g.status = ST_OOM;
            return g;
        end
        // First fit, newest entry first; the entries above the hit close up.
        for (k = free_len - 1; k >= 0; k--) begin
            if (free_size_q[k] >= req) begin
                g.addr   = free_addr_q[k];
                g.reused = 1'b1;
                for (j = k; j < free_len - 1; j++) begin
                    free_addr_q[j] = free_addr_q[j + 1];
                    free_size_q[j] = free_size_q[j + 1];
                end
                free_len--;
                return g;
            end
        end
        // Nothing on the list fits: carve a fresh block from the bump pointer.
        data_bytes = (int'(req) < MIN_DATA_BYTES) ? MIN_DATA_BYTES : int'(req);
        data_bytes = (data_bytes + 7) & ~7;
        if (bump_ptr + HEADER_BYTES + data_bytes > arena_limit) begin
            g.status = ST_OOM;
            return g;
        end
        g.addr = t_addr'(bump_ptr + HEADER_BYTES);
        bump_ptr += HEADER_BYTES + data_bytes;
        block_size_mem[g.addr >> 3] = t_size'(data_bytes);
        return g;
    endfunction

    // Present one request, wait for it to be taken and record what it should give.
    task automatic issue_request(logic fn, t_size req, t_addr fa, logic typed, t_grant typed_g);
        t_grant g;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, fa, req};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        g = predict_grant(fn, req, fa);
        pending_grants.push_back(typed ? typed_g : g);
        if (fn == FN_ALLOC && g.status == ST_OK) begin
            held_blocks.push_back(g.addr);
            if (!g.reused) begin
                carved_blocks.push_back(g.addr);
            end
        end
    endtask

    // Drain every outstanding request, then write the arena size.
    task automatic write_arena(t_size value);
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        arena_limit = (int'(value) > ARENA_BYTES) ? ARENA_BYTES : int'(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare every accepted result with the oldest outstanding grant.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_grants.size() == 0) begin
                $error("result with no request outstanding: data_address %0d status %0d",
                       m_axis_tdata[13:0], m_axis_tdata[15:14]);
                n_errors++;
            end else begin
                want = pending_grants.pop_front();
                if (m_axis_tdata[13:0] !== want.addr) begin
                    $error("data_address mismatch: expected %0d, got %0d",
                           want.addr, m_axis_tdata[13:0]);
                    n_errors++;
                end
                if (m_axis_tdata[15:14] !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, m_axis_tdata[15:14]);
                    n_errors++;
                end
                if (m_axis_tuser[0] !== want.reused) begin
                    $error("reused mismatch: expected %0d, got %0d",
                           want.reused, m_axis_tuser[0]);
                    n_errors++;
                end
            end
        end
    end

    // Give up when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_step_row row;
        int        phase;
        int        n;
        int        sel;
        int        idx;
        t_size     req;
        t_addr     fa;
        logic      fn;

        arena_limit = 0;
        bump_ptr    = 0;
        free_len    = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (n = 0; n < DIRECTED_LEN; n++) begin
            row = directed_rows[n];
            if (row.set_arena) begin
                write_arena(row.arena);
            end
            issue_request(row.fn, row.req, row.fa, row.typed,
                          '{row.ex_addr, row.ex_status, row.ex_reused});
        end

        // Random phases, each starting from an idle block with a new arena size.
        for (phase = 0; phase < 6; phase++) begin
            unique case (phase / 2)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 73;
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            unique case (phase)
                1:       write_arena(t_size'($urandom_range(64, 4096)));
                2:       write_arena(15'd32767);
                4:       write_arena(t_size'($urandom_range(1, 16383)));
                default: write_arena(15'd16384);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(99);
                if (sel < 50 && carved_blocks.size() != 0) begin
                    // Mostly release a held block; otherwise a double free or an
                    // unaligned address inside a recorded block.
                    fn  = FN_FREE;
                    req = t_size'($urandom);
                    if ($urandom_range(99) < 85 && held_blocks.size() != 0) begin
                        idx = $urandom_range(held_blocks.size() - 1);
                        fa  = held_blocks[idx];
                        held_blocks.delete(idx);
                    end else begin
                        idx = $urandom_range(carved_blocks.size() - 1);
                        fa  = carved_blocks[idx] | t_addr'($urandom_range(7));
                    end
                end else begin
                    // Mostly small requests so the arena lasts and blocks get reused.
                    fn  = FN_ALLOC;
                    fa  = t_addr'($urandom);
                    sel = $urandom_range(99);
                    if (sel < 80) begin
                        req = t_size'($urandom_range(24));
                    end else if (sel < 95) begin
                        req = t_size'($urandom_range(25, 512));
                    end else if (sel < 99) begin
                        req = t_size'($urandom_range(513, 16384));
                    end else begin
                        req = t_size'($urandom_range(16385, 32767));
                    end
                end
                issue_request(fn, req, fa, 1'b0, '0);
            end
        end

        // Let the last results come out, then allow a little extra time.
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (FREE_DEPTH + 8) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
